// File: rtl/core/svoi_pkg.sv
`timescale 1ns / 1ps

package svoi_pkg;

   localparam int MAX_DEPTH_DEF   = 8;
   localparam int LEVEL_NODES_DEF = 4096;
   localparam int CHILDREN        = 8;
   localparam int MASK_W          = 8;
   localparam int COORD_W         = 8;
   localparam int DEPTH_CFG_W     = 4;
   localparam int LEAF_W          = 12;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;
   localparam int REQ_DATA_W      = 24;
   localparam int RSP_DATA_W      = 16;

   localparam logic [DEPTH_CFG_W-1:0] TREE_DEPTH_RESET = 4'd8;

   // Word index of the tree_depth register (byte address 0).
   localparam logic CSR_IDX_TREE_DEPTH = 1'b0;

   // Bit positions of the flags in the result tdata.
   localparam int RSP_PRESENT_BIT = 12;
   localparam int RSP_FULL_BIT    = 13;
   localparam int RSP_OOR_BIT     = 14;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_READ   = 4'b0010,
      ST_MODIFY = 4'b0100,
      ST_RESULT = 4'b1000
   } walk_state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } store_ctrl_type;

endpackage

// File: rtl/core/sparse_octree_voxel_insert_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// req_      in         tvalid / tready    coord_x, coord_y, coord_z
// rsp_      out        tvalid / tready    leaf_index, already_present, store_full, out_of_range
// csr_      in         psel / penable     tree_depth at byte address 0
//
// Items are taken one at a time: each is accepted, then walked with one memory read and one
// read-modify-write per level of the node store, then its result is handed to the
// output register. Out-of-range items skip the walk; a full level ends it early.
// After reset the node store clears all MAX_DEPTH*LEVEL_NODES entries
// (32768 by default); req_tready stays low during that sweep.
// A stalled result only holds the walk once a second result is finished.

module sparse_octree_voxel_insert_core #(
   parameter int MAX_DEPTH   = svoi_pkg::MAX_DEPTH_DEF,
   parameter int LEVEL_NODES = svoi_pkg::LEVEL_NODES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // coord_x [7:0], coord_y [15:8], coord_z [23:16]
   input  logic [svoi_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // leaf_index [11:0], already_present [12], store_full [13], out_of_range [14], zero [15]
   output logic [svoi_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [svoi_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [svoi_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [svoi_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import svoi_pkg::*;

   localparam int NODE_W      = $clog2(LEVEL_NODES);
   localparam int ENTRY_W     = MASK_W + NODE_W;
   localparam int STORE_DEPTH = MAX_DEPTH * LEVEL_NODES;
   localparam int AW          = $clog2(STORE_DEPTH);
   localparam int LW          = $clog2(MAX_DEPTH + 1);
   localparam int LIW         = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int FW          = $clog2(LEVEL_NODES + 1);

   walk_state_type       state_ff, state_in;
   logic [LW-1:0]        level_ff, level_in;
   logic [NODE_W-1:0]    idx_ff, idx_in;
   logic [COORD_W-1:0]   x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [LEAF_W-1:0]    res_leaf_ff, res_leaf_in;
   logic                 res_present_ff, res_present_in;
   logic                 res_full_ff, res_full_in;
   logic                 res_oor_ff, res_oor_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [FW-1:0]        fill_ff [MAX_DEPTH];
   logic [FW-1:0]        fill_in [MAX_DEPTH];
   logic [DEPTH_CFG_W-1:0] tree_depth_ff, tree_depth_in;

   logic [COORD_W-1:0]   req_x, req_y, req_z;
   logic [4:0]           cfg_ext, eff_depth;
   logic                 req_oor;
   logic                 csr_write;

   logic [LW-1:0]        pos;
   logic [COORD_W-1:0]   xs, ys, zs;
   logic [2:0]           oct;
   logic [MASK_W-1:0]    oct_bit, mask, new_mask;
   logic [NODE_W-1:0]    base, new_base, next_idx;
   logic [FW-1:0]        fill;
   logic                 need_alloc, level_full, hit;
   logic [31:0]          next_idx_wide;

   store_ctrl_type       store_ctrl;
   logic [AW-1:0]        node_addr;
   logic [ENTRY_W-1:0]   rd_data, wr_data;
   logic                 store_busy;

   assign req_x = req_tdata[COORD_W-1:0];
   assign req_y = req_tdata[2*COORD_W-1:COORD_W];
   assign req_z = req_tdata[3*COORD_W-1:2*COORD_W];

   // A depth of zero acts as one; anything above MAX_DEPTH acts as MAX_DEPTH.
   assign cfg_ext   = {1'b0, tree_depth_ff};
   assign eff_depth = (tree_depth_ff == '0) ? 5'd1 :
                      (cfg_ext > 5'(MAX_DEPTH)) ? 5'(MAX_DEPTH) : cfg_ext;
   assign req_oor   = ((req_x >> eff_depth) != '0) || ((req_y >> eff_depth) != '0) ||
                      ((req_z >> eff_depth) != '0);

   // Per-level octant: a coordinate bit of zero at position level-1 means the
   // lower half, which sets the octant bit.
   assign pos     = level_ff - 1'b1;
   assign xs      = x_ff >> pos;
   assign ys      = y_ff >> pos;
   assign zs      = z_ff >> pos;
   assign oct     = {~zs[0], ~ys[0], ~xs[0]};
   assign oct_bit = MASK_W'(1) << oct;

   assign mask       = rd_data[MASK_W-1:0];
   assign base       = rd_data[ENTRY_W-1:MASK_W];
   assign fill       = fill_ff[pos[LIW-1:0]];
   assign need_alloc = (mask == '0);
   assign level_full = need_alloc &&
                       (({1'b0, fill} + (FW+1)'(CHILDREN)) > (FW+1)'(LEVEL_NODES));
   assign new_base   = need_alloc ? NODE_W'(fill) : base;
   assign new_mask   = mask | oct_bit;
   assign hit        = |(mask & oct_bit);
   assign next_idx   = new_base + NODE_W'(oct);
   assign next_idx_wide = 32'(next_idx);

   assign node_addr = AW'(32'(pos) * 32'(LEVEL_NODES) + 32'(idx_ff));
   assign wr_data   = {new_base, new_mask};

   assign store_ctrl.rd_en = (state_ff == ST_READ);
   assign store_ctrl.wr_en = (state_ff == ST_MODIFY) && !level_full;

   svoi_node_store #(
      .ENTRY_W     (ENTRY_W),
      .STORE_DEPTH (STORE_DEPTH)
   ) u_node_store (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (store_ctrl),
      .rd_addr (node_addr),
      .rd_data (rd_data),
      .wr_addr (node_addr),
      .wr_data (wr_data),
      .busy    (store_busy)
   );

   assign req_tready = (state_ff == ST_IDLE) && !store_busy;

   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_TREE_DEPTH) ? CSR_DATA_W'(tree_depth_ff) : '0;

   always_comb begin
      state_in       = state_ff;
      level_in       = level_ff;
      idx_in         = idx_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      z_in           = z_ff;
      res_leaf_in    = res_leaf_ff;
      res_present_in = res_present_ff;
      res_full_in    = res_full_ff;
      res_oor_in     = res_oor_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      fill_in        = fill_ff;
      tree_depth_in  = tree_depth_ff;

      if (csr_write && (csr_paddr[2] == CSR_IDX_TREE_DEPTH)) begin
         tree_depth_in = csr_pwdata[DEPTH_CFG_W-1:0];
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               x_in           = req_x;
               y_in           = req_y;
               z_in           = req_z;
               level_in       = LW'(eff_depth);
               idx_in         = '0;
               res_leaf_in    = '0;
               res_present_in = 1'b0;
               res_full_in    = 1'b0;
               res_oor_in     = req_oor;
               state_in       = req_oor ? ST_RESULT : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            if (level_full) begin
               res_full_in = 1'b1;
               state_in    = ST_RESULT;
            end else begin
               if (need_alloc) begin
                  fill_in[pos[LIW-1:0]] = fill + FW'(CHILDREN);
               end
               idx_in   = next_idx;
               level_in = level_ff - 1'b1;
               if (level_ff == LW'(1)) begin
                  res_leaf_in    = next_idx_wide[LEAF_W-1:0];
                  res_present_in = hit;
                  state_in       = ST_RESULT;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, res_oor_ff, res_full_ff, res_present_ff, res_leaf_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         tree_depth_ff <= TREE_DEPTH_RESET;
         for (int i = 0; i < MAX_DEPTH; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         tree_depth_ff <= tree_depth_in;
         fill_ff       <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff       <= level_in;
      idx_ff         <= idx_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      z_ff           <= z_in;
      res_leaf_ff    <= res_leaf_in;
      res_present_ff <= res_present_in;
      res_full_ff    <= res_full_in;
      res_oor_ff     <= res_oor_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The modify step always works on data read in the cycle before.
   a_modify_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MODIFY) |-> ($past(state_ff) == ST_READ))
      else $error("modify step without a preceding node read");

   // No item may enter while the node store is still being cleared.
   a_no_accept_during_clear: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !store_busy)
      else $error("item accepted during node store clearing");

   // An out-of-range result carries no leaf, no hit and no full flag.
   a_oor_result_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[RSP_OOR_BIT]) |->
         (rsp_tdata[LEAF_W-1:0] == '0 && !rsp_tdata[RSP_PRESENT_BIT] &&
          !rsp_tdata[RSP_FULL_BIT]))
      else $error("out-of-range result with other fields set");

   // A full level ends the walk at once.
   a_full_ends_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MODIFY && level_full) |=> (state_ff == ST_RESULT))
      else $error("walk continued past a full level");

endmodule

// File: rtl/core/svoi_node_store.sv
`timescale 1ns / 1ps

module svoi_node_store #(
   parameter int ENTRY_W     = 20,
   parameter int STORE_DEPTH = 32768
) (
   input  logic                          clock,
   input  logic                          reset,
   input  svoi_pkg::store_ctrl_type      ctrl,
   input  logic [$clog2(STORE_DEPTH)-1:0] rd_addr,
   output logic [ENTRY_W-1:0]            rd_data,
   input  logic [$clog2(STORE_DEPTH)-1:0] wr_addr,
   input  logic [ENTRY_W-1:0]            wr_data,
   output logic                          busy
);
   import svoi_pkg::*;

   localparam int AW = $clog2(STORE_DEPTH);

   logic [ENTRY_W-1:0] mem [STORE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [AW-1:0]      clr_addr_ff, clr_addr_in;
   logic               clr_busy_ff, clr_busy_in;

   // After reset every entry is swept to zero, one entry per cycle.
   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(STORE_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (ctrl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

endmodule
